// ===== hdl/lc3ie_pkg.sv =====
// ----------------------------------------------------------------------------
// lc3ie_pkg
// Shared types and constants for the LC-3 subset execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lc3ie_pkg;

  localparam int unsigned ADDR_BITS = 16;
  localparam logic [15:0] START_PC_RESET = 16'h3000;

  localparam logic [3:0] OPC_BR   = 4'h0;
  localparam logic [3:0] OPC_ADD  = 4'h1;
  localparam logic [3:0] OPC_LD   = 4'h2;
  localparam logic [3:0] OPC_JSR  = 4'h4;
  localparam logic [3:0] OPC_AND  = 4'h5;
  localparam logic [3:0] OPC_LDR  = 4'h6;
  localparam logic [3:0] OPC_NOT  = 4'h9;
  localparam logic [3:0] OPC_JMP  = 4'hC;
  localparam logic [3:0] OPC_TRAP = 4'hF;

  localparam logic [7:0] VEC_GETC = 8'h20;
  localparam logic [7:0] VEC_OUT  = 8'h21;
  localparam logic [7:0] VEC_IN   = 8'h23;
  localparam logic [7:0] VEC_HALT = 8'h25;

  // memory address select
  typedef enum logic [1:0] {
    MA_LOAD = 2'd0,
    MA_PC   = 2'd1,
    MA_DATA = 2'd2
  } maddr_sel_t;

  // controller to datapath
  typedef struct packed {
    logic       mem_we;
    logic       mem_re;
    maddr_sel_t maddr;
    logic       latch_req;
    logic       exec;      // execute instruction held in fetch register
    logic       finish;    // writeback of a load-type instruction
    logic       set_pc;    // config write
  } lc3ie_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_load;         // LD or LDR
    logic stopped;
  } lc3ie_sts_t;

endpackage

`default_nettype wire

// ===== hdl/lc3ie_ctrl.sv =====
// ----------------------------------------------------------------------------
// lc3ie_ctrl
// Sequencer: load, fetch, execute, data read and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module lc3ie_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 operation,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  input  wire logic                 cfg_we,
  input  wire lc3ie_pkg::lc3ie_sts_t sts,
  output lc3ie_pkg::lc3ie_cmd_t     cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_EXEC  = 5'b00100,
    S_DATA  = 5'b01000,
    S_WB    = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   res_valid, res_valid_next;
  logic   take;

  // one result slot; new request taken only with the slot free or draining
  assign in_stall  = (state != S_IDLE) || (res_valid && out_stall);
  assign take      = in_valid && !in_stall;
  assign out_valid = res_valid;

  always_comb begin
    state_next     = state;
    res_valid_next = res_valid && out_stall;
    cmd            = '0;
    cmd.maddr      = lc3ie_pkg::MA_LOAD;
    cmd.set_pc     = cfg_we;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          cmd.latch_req = 1'b1;
          if (!operation) begin
            cmd.mem_we     = 1'b1;
            res_valid_next = 1'b1;
          end else if (sts.stopped) begin
            res_valid_next = 1'b1;
          end else begin
            cmd.mem_re = 1'b1;
            cmd.maddr  = lc3ie_pkg::MA_PC;
            state_next = S_FETCH;
          end
        end
      end
      S_FETCH: state_next = S_EXEC;
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.is_load) begin
          state_next = S_DATA;
        end else begin
          res_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_DATA: begin
        cmd.mem_re = 1'b1;
        cmd.maddr  = lc3ie_pkg::MA_DATA;
        state_next = S_WB;
      end
      S_WB: begin
        cmd.finish     = 1'b1;
        res_valid_next = 1'b1;
        state_next     = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lc3ie_datapath.sv =====
// ----------------------------------------------------------------------------
// lc3ie_datapath
// Memory, register file, pc, flags and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lc3ie_datapath (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire lc3ie_pkg::lc3ie_cmd_t cmd,
  output lc3ie_pkg::lc3ie_sts_t      sts,
  input  wire logic [15:0]           address,
  input  wire logic [15:0]           data,
  input  wire logic [7:0]            key_char,
  input  wire logic [15:0]           cfg_data,
  output logic [15:0]                next_pc,
  output logic [2:0]                 condition,
  output logic [7:0]                 out_char,
  output logic                       char_valid,
  output logic                       halted,
  output logic                       fault
);

  localparam int unsigned AW = lc3ie_pkg::ADDR_BITS;

  logic [15:0] mem [0:(2**AW)-1];
  logic [15:0] mem_q;
  logic [AW-1:0] maddr;

  logic [15:0] regs [0:7];
  logic [15:0] pc;
  logic [2:0]  flags;
  logic        stopped;
  logic [7:0]  key_q;
  logic [15:0] ins;
  logic [2:0]  ld_dr;
  logic [15:0] data_addr;

  logic [3:0]  opc;
  logic [2:0]  dr, sr1;
  logic [15:0] rs1, rs2, opnd, alu, pc1;
  logic [15:0] off9, off11, off6, imm5;

  function automatic logic [2:0] nzp(input logic [15:0] v);
    priority if (v == 16'h0) nzp = 3'b010;
    else if (v[15])          nzp = 3'b100;
    else                     nzp = 3'b001;
  endfunction

  always_comb begin
    unique case (cmd.maddr)
      lc3ie_pkg::MA_PC:   maddr = pc[AW-1:0];
      lc3ie_pkg::MA_DATA: maddr = data_addr[AW-1:0];
      default:            maddr = address[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) mem[maddr] <= data;
    if (cmd.mem_re) mem_q <= mem[maddr];
  end

  assign ins   = mem_q;
  assign opc   = ins[15:12];
  assign dr    = ins[11:9];
  assign sr1   = ins[8:6];
  assign rs1   = regs[sr1];
  assign rs2   = regs[ins[2:0]];
  assign imm5  = {{11{ins[4]}}, ins[4:0]};
  assign off6  = {{10{ins[5]}}, ins[5:0]};
  assign off9  = {{7{ins[8]}}, ins[8:0]};
  assign off11 = {{5{ins[10]}}, ins[10:0]};
  assign opnd  = ins[5] ? imm5 : rs2;
  assign alu   = (opc == lc3ie_pkg::OPC_ADD) ? rs1 + opnd : rs1 & opnd;
  assign pc1   = pc + 16'd1;

  assign sts.is_load = (opc == lc3ie_pkg::OPC_LD) || (opc == lc3ie_pkg::OPC_LDR);
  assign sts.stopped = stopped;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc      <= lc3ie_pkg::START_PC_RESET;
      flags   <= '0;
      stopped <= 1'b0;
      for (int i = 0; i < 8; i++) regs[i] <= '0;
      char_valid <= 1'b0;
      fault      <= 1'b0;
      out_char   <= '0;
    end else begin
      if (cmd.set_pc) pc <= cfg_data;
      if (cmd.latch_req) begin
        key_q      <= key_char;
        char_valid <= 1'b0;
        fault      <= 1'b0;
        out_char   <= '0;
      end
      if (cmd.exec) begin
        pc <= pc1;
        unique case (opc)
          lc3ie_pkg::OPC_ADD, lc3ie_pkg::OPC_AND: begin
            regs[dr] <= alu;
            flags    <= nzp(alu);
          end
          lc3ie_pkg::OPC_NOT: begin
            regs[dr] <= ~rs1;
            flags    <= nzp(~rs1);
          end
          lc3ie_pkg::OPC_BR: begin
            if ((dr & flags) != 3'b000) pc <= pc1 + off9;
          end
          lc3ie_pkg::OPC_JMP: pc <= rs1;
          lc3ie_pkg::OPC_JSR: begin
            regs[7] <= pc1;
            pc      <= ins[11] ? pc1 + off11 : rs1;
          end
          lc3ie_pkg::OPC_LD: begin
            data_addr <= pc1 + off9;
            ld_dr     <= dr;
          end
          lc3ie_pkg::OPC_LDR: begin
            data_addr <= rs1 + off6;
            ld_dr     <= dr;
          end
          lc3ie_pkg::OPC_TRAP: begin
            unique case (ins[7:0])
              lc3ie_pkg::VEC_GETC, lc3ie_pkg::VEC_IN: regs[0] <= {8'h00, key_q};
              lc3ie_pkg::VEC_OUT: begin
                out_char   <= regs[0][7:0];
                char_valid <= 1'b1;
              end
              lc3ie_pkg::VEC_HALT: stopped <= 1'b1;
              default: ;
            endcase
          end
          default: begin
            fault   <= 1'b1;
            stopped <= 1'b1;
          end
        endcase
      end
      if (cmd.finish) begin
        regs[ld_dr] <= mem_q;
        flags       <= nzp(mem_q);
      end
    end
  end

  assign next_pc   = pc;
  assign condition = flags;
  assign halted    = stopped;

endmodule

`default_nettype wire

// ===== hdl/lc3_instruction_execute_unit.sv =====
// ----------------------------------------------------------------------------
// lc3_instruction_execute_unit
// LC-3 subset core executing one instruction or memory load per request.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with operation, address, data, key_char.
// operation 0 writes one memory word; operation 1 executes one instruction.
// Output channel: out_valid/out_stall, one result per request carrying
// next_pc, condition, out_char, char_valid, halted and fault.
// A load or a step while halted gives its result in the cycle after
// acceptance; an instruction passes fetch read, execute and result, and
// LD/LDR also read data, since the single-port memory is read a second time.
// A new request can be taken in the cycle its predecessor's result is taken.
// Result state is held while out_stall is high; the input then stalls.
// cfg_we/cfg_data write start_pc and load the program counter; write only
// while idle. Reset clears registers and flags, sets pc to 0x3000 and
// leaves memory contents undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module lc3_instruction_execute_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        operation,
  input  wire logic [15:0] address,
  input  wire logic [15:0] data,
  input  wire logic [7:0]  key_char,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      next_pc,
  output logic [2:0]       condition,
  output logic [7:0]       out_char,
  output logic             char_valid,
  output logic             halted,
  output logic             fault,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data
);

  lc3ie_pkg::lc3ie_cmd_t cmd;
  lc3ie_pkg::lc3ie_sts_t sts;

  lc3ie_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .out_stall(out_stall), .out_valid(out_valid),
    .cfg_we(cfg_we), .sts(sts), .cmd(cmd)
  );

  lc3ie_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .address(address), .data(data),
    .key_char(key_char), .cfg_data(cfg_data), .next_pc(next_pc),
    .condition(condition), .out_char(out_char), .char_valid(char_valid),
    .halted(halted), .fault(fault)
  );

endmodule

`default_nettype wire

// ===== tb/tb_lc3_instruction_execute_unit.sv =====
// ----------------------------------------------------------------------------
// tb_lc3_instruction_execute_unit
// Self-checking bench for the LC-3 subset execute unit: a predictor tracks
// memory, registers, pc, flags and the halt mark; every result is compared
// field by field with the oldest prediction under random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lc3_instruction_execute_unit;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ITEMS   = 1750;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [2:0]  condition;
    logic [7:0]  out_char;
    logic        char_valid;
    logic        halted;
    logic        fault;
  } exec_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = 1'b0;
  logic [15:0] address = '0;
  logic [15:0] data = '0;
  logic [7:0]  key_char = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] next_pc;
  logic [2:0]  condition;
  logic [7:0]  out_char;
  logic        char_valid;
  logic        halted;
  logic        fault;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;

  lc3_instruction_execute_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .address(address), .data(data), .key_char(key_char),
    .out_valid(out_valid), .out_stall(out_stall),
    .next_pc(next_pc), .condition(condition), .out_char(out_char),
    .char_valid(char_valid), .halted(halted), .fault(fault),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted machine state
  logic [15:0] mem_word [65536];
  bit          mem_written [65536];
  logic [15:0] gpr [8];
  logic [15:0] pc_q;
  logic [2:0]  flags_q;
  bit          stopped_q;

  exec_result_t expected_results[$];
  int errors = 0;
  int n_requests = 0;
  int n_results = 0;
  int n_chars = 0;
  int idle_cycles = 0;
  bit long_hold = 1'b0;

  function automatic logic [2:0] nzp_of(logic [15:0] v);
    if (v == 16'h0) return 3'b010;
    else if (v[15]) return 3'b100;
    else return 3'b001;
  endfunction

  function automatic exec_result_t execute_item(bit op, logic [15:0] a, logic [15:0] d,
                                                logic [7:0] k);
    exec_result_t r;
    logic [15:0] ins;
    logic [15:0] v;
    logic [3:0] opc;
    logic [2:0] dr;
    logic [2:0] sr1;
    r = '0;
    if (!op) begin
      mem_word[a] = d;
      mem_written[a] = 1'b1;
    end else if (!stopped_q) begin
      ins = mem_word[pc_q];
      opc = ins[15:12];
      dr = ins[11:9];
      sr1 = ins[8:6];
      pc_q = pc_q + 16'd1;
      case (opc)
        lc3ie_pkg::OPC_ADD, lc3ie_pkg::OPC_AND: begin
          v = ins[5] ? {{11{ins[4]}}, ins[4:0]} : gpr[ins[2:0]];
          v = (opc == lc3ie_pkg::OPC_ADD) ? gpr[sr1] + v : gpr[sr1] & v;
          gpr[dr] = v;
          flags_q = nzp_of(v);
        end
        lc3ie_pkg::OPC_NOT: begin
          v = ~gpr[sr1];
          gpr[dr] = v;
          flags_q = nzp_of(v);
        end
        lc3ie_pkg::OPC_BR: begin
          if ((dr & flags_q) != 3'b000) pc_q = pc_q + {{7{ins[8]}}, ins[8:0]};
        end
        lc3ie_pkg::OPC_JMP: pc_q = gpr[sr1];
        lc3ie_pkg::OPC_JSR: begin
          v = gpr[sr1];
          gpr[7] = pc_q;
          pc_q = ins[11] ? pc_q + {{5{ins[10]}}, ins[10:0]} : v;
        end
        lc3ie_pkg::OPC_LD, lc3ie_pkg::OPC_LDR: begin
          v = (opc == lc3ie_pkg::OPC_LD) ? mem_word[pc_q + {{7{ins[8]}}, ins[8:0]}]
                                         : mem_word[gpr[sr1] + {{10{ins[5]}}, ins[5:0]}];
          gpr[dr] = v;
          flags_q = nzp_of(v);
        end
        lc3ie_pkg::OPC_TRAP: begin
          case (ins[7:0])
            lc3ie_pkg::VEC_GETC, lc3ie_pkg::VEC_IN: gpr[0] = {8'h00, k};
            lc3ie_pkg::VEC_OUT: begin
              r.out_char = gpr[0][7:0];
              r.char_valid = 1'b1;
            end
            lc3ie_pkg::VEC_HALT: stopped_q = 1'b1;
            default: ;
          endcase
        end
        default: begin
          r.fault = 1'b1;
          stopped_q = 1'b1;
        end
      endcase
    end
    r.next_pc = pc_q;
    r.condition = flags_q;
    r.halted = stopped_q;
    return r;
  endfunction

  // sender: random bursts and gaps, in_valid held high between back-to-back requests
  int burst_left = 0;

  task automatic send_request(bit op, logic [15:0] a, logic [15:0] d, logic [7:0] k);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    expected_results.push_back(execute_item(op, a, d, k));
    n_requests++;
    in_valid <= 1'b1;
    operation <= op;
    address <= a;
    data <= d;
    key_char <= k;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic load_word(logic [15:0] a, logic [15:0] d);
    send_request(1'b0, a, d, 8'($urandom));
  endtask

  // places ins at the predicted pc, backs any LD/LDR target with data, then steps
  task automatic run_instr(logic [15:0] ins, logic [7:0] k);
    logic [15:0] target;
    load_word(pc_q, ins);
    if (!stopped_q && (ins[15:12] == lc3ie_pkg::OPC_LD ||
                       ins[15:12] == lc3ie_pkg::OPC_LDR)) begin
      target = (ins[15:12] == lc3ie_pkg::OPC_LD)
               ? pc_q + 16'd1 + {{7{ins[8]}}, ins[8:0]}
               : gpr[ins[8:6]] + {{10{ins[5]}}, ins[5:0]};
      if (!mem_written[target] || $urandom_range(0, 1)) begin
        if (target != pc_q) load_word(target, 16'($urandom));
      end
    end
    send_request(1'b1, 16'($urandom), 16'($urandom), k);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    // a late write may still be in flight, allow the longest instruction
    repeat (8) @(posedge clk);
  endtask

  task automatic write_start_pc(logic [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pc_q = v;
  endtask

  function automatic logic [15:0] random_safe_instr();
    logic [15:0] ins;
    logic [7:0] vec;
    ins = 16'($urandom);
    case ($urandom_range(0, 11))
      0, 1: ins[15:12] = lc3ie_pkg::OPC_ADD;
      2: ins[15:12] = lc3ie_pkg::OPC_AND;
      3: ins[15:12] = lc3ie_pkg::OPC_NOT;
      4, 5: ins[15:12] = lc3ie_pkg::OPC_BR;
      6: ins[15:12] = lc3ie_pkg::OPC_JMP;
      7: ins[15:12] = lc3ie_pkg::OPC_JSR;
      8: ins[15:12] = lc3ie_pkg::OPC_LD;
      9: ins[15:12] = lc3ie_pkg::OPC_LDR;
      default: begin
        ins[15:12] = lc3ie_pkg::OPC_TRAP;
        case ($urandom_range(0, 4))
          0: vec = lc3ie_pkg::VEC_GETC;
          1: vec = lc3ie_pkg::VEC_IN;
          2, 3: vec = lc3ie_pkg::VEC_OUT;
          default: begin
            vec = 8'($urandom);
            if (vec == lc3ie_pkg::VEC_HALT) vec = 8'h22;
          end
        endcase
        ins[7:0] = vec;
      end
    endcase
    return ins;
  endfunction

  function automatic bit safe_to_rerun(logic [15:0] ins);
    case (ins[15:12])
      lc3ie_pkg::OPC_ADD, lc3ie_pkg::OPC_AND, lc3ie_pkg::OPC_NOT,
      lc3ie_pkg::OPC_BR, lc3ie_pkg::OPC_JMP, lc3ie_pkg::OPC_JSR: return 1'b1;
      lc3ie_pkg::OPC_TRAP: return ins[7:0] != lc3ie_pkg::VEC_HALT;
      default: return 1'b0;
    endcase
  endfunction

  // ---------------- tests ----------------

  task automatic test_directed_ops;
    run_instr({lc3ie_pkg::OPC_BR, 3'b111, 9'h0F0}, 8'h00);    // flags clear: never taken
    run_instr({lc3ie_pkg::OPC_TRAP, 4'h0, lc3ie_pkg::VEC_GETC}, 8'hFF); // r0 = 0x00ff
    run_instr({lc3ie_pkg::OPC_ADD, 3'd1, 3'd0, 1'b1, 5'h10}, 8'h00); // r1 = r0 - 16
    run_instr({lc3ie_pkg::OPC_ADD, 3'd2, 3'd1, 1'b0, 2'b00, 3'd0}, 8'h00);
    run_instr({lc3ie_pkg::OPC_AND, 3'd3, 3'd2, 1'b1, 5'h00}, 8'h00); // zero result
    run_instr({lc3ie_pkg::OPC_AND, 3'd4, 3'd2, 1'b0, 2'b00, 3'd1}, 8'h00);
    run_instr({lc3ie_pkg::OPC_NOT, 3'd5, 3'd3, 6'h3F}, 8'h00);  // negative result
    run_instr({lc3ie_pkg::OPC_BR, 3'b100, 9'h1FF}, 8'h00);      // taken backward
    run_instr({lc3ie_pkg::OPC_BR, 3'b011, 9'h005}, 8'h00);      // not taken
    run_instr({lc3ie_pkg::OPC_TRAP, 4'h0, lc3ie_pkg::VEC_IN}, 8'h41);
    run_instr({lc3ie_pkg::OPC_TRAP, 4'h0, lc3ie_pkg::VEC_OUT}, 8'h00);
    run_instr({lc3ie_pkg::OPC_TRAP, 4'h0, 8'h22}, 8'h00);       // puts: no effect
    run_instr({lc3ie_pkg::OPC_TRAP, 4'h0, 8'hFF}, 8'h00);       // unknown vector
    run_instr({lc3ie_pkg::OPC_JSR, 1'b1, 11'h400}, 8'h00);      // jsr, most negative offset
    run_instr({lc3ie_pkg::OPC_JSR, 1'b0, 2'b00, 3'd7, 6'h00}, 8'h00); // jsrr via r7
    run_instr({lc3ie_pkg::OPC_LD, 3'd6, 9'h0FF}, 8'h00);
    run_instr({lc3ie_pkg::OPC_LDR, 3'd6, 3'd0, 6'h20}, 8'h00);
    run_instr({lc3ie_pkg::OPC_JMP, 3'd0, 3'd5, 6'h00}, 8'h00);
    load_word(16'h0000, 16'hFFFF);
    load_word(16'hFFFF, 16'h0000);
  endtask

  task automatic test_pc_extremes;
    write_start_pc(16'hFFFF);
    run_instr({lc3ie_pkg::OPC_ADD, 3'd0, 3'd0, 1'b1, 5'h0F}, 8'h00); // pc wraps to 0
    run_instr({lc3ie_pkg::OPC_NOT, 3'd1, 3'd0, 6'h3F}, 8'h00);
    write_start_pc(16'h0000);
    run_instr({lc3ie_pkg::OPC_BR, 3'b111, 9'h100}, 8'h00);      // pc wraps backward
    run_instr({lc3ie_pkg::OPC_JMP, 3'd0, 3'd0, 6'h00}, 8'h00);
  endtask

  task automatic test_random_programs;
    logic [15:0] ins;
    int chunk;
    for (chunk = 0; chunk < 4; chunk++) begin
      write_start_pc(chunk == 0 ? 16'h3000 : 16'($urandom));
      while (n_requests < (chunk + 1) * RANDOM_ITEMS / 4) begin
        if ($urandom_range(0, 9) == 0) begin
          load_word(16'($urandom), 16'($urandom));   // stray memory writes
        end else if (mem_written[pc_q] && safe_to_rerun(mem_word[pc_q]) &&
                     $urandom_range(0, 3) == 0) begin
          send_request(1'b1, 16'($urandom), 16'($urandom), 8'($urandom));
        end else begin
          ins = random_safe_instr();
          run_instr(ins, 8'($urandom));
        end
      end
    end
  endtask

  task automatic test_backpressure;
    int i;
    drain();
    long_hold = 1'b1;
    for (i = 0; i < 30; i++) run_instr(random_safe_instr(), 8'($urandom));
    drain();   // sender waits for every result
  endtask

  task automatic test_halt_and_fault;
    run_instr({4'h3, 12'h123}, 8'h00);                    // store: not supported
    send_request(1'b1, 16'h0, 16'h0, 8'h00);               // step while stopped
    load_word(16'h1234, 16'hABCD);                         // load while stopped
    write_start_pc(16'h5000);                              // stop mark stays set
    send_request(1'b1, 16'hFFFF, 16'hFFFF, 8'hFF);
    run_instr({lc3ie_pkg::OPC_TRAP, 4'h0, lc3ie_pkg::VEC_HALT}, 8'h00);
    drain();
  endtask

  // ---------------- receiver and checker ----------------

  int stall_mode = 0;
  int mode_cycles = 0;
  int hold_cycles = 0;

  always @(posedge clk) begin
    if (long_hold && hold_cycles == 0) begin
      hold_cycles <= 300;
      long_hold <= 1'b0;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= (hold_cycles > 1);
    end else begin
      if (mode_cycles == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_cycles <= $urandom_range(20, 120);
      end else begin
        mode_cycles <= mode_cycles - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= (mode_cycles % 4 == 0);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  always @(posedge clk) begin
    exec_result_t exp_r;
    exec_result_t got_r;
    if (!rst && out_valid && !out_stall) begin
      got_r = '{next_pc, condition, out_char, char_valid, halted, fault};
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request pending: %p", $time, got_r);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        n_results++;
        if (got_r.char_valid) n_chars++;
        if (got_r.next_pc !== exp_r.next_pc) begin
          $display("%0t: next_pc expected %h actual %h", $time, exp_r.next_pc, got_r.next_pc);
          errors++;
        end
        if (got_r.condition !== exp_r.condition) begin
          $display("%0t: condition expected %b actual %b", $time,
                   exp_r.condition, got_r.condition);
          errors++;
        end
        if (got_r.out_char !== exp_r.out_char) begin
          $display("%0t: out_char expected %h actual %h", $time, exp_r.out_char, got_r.out_char);
          errors++;
        end
        if (got_r.char_valid !== exp_r.char_valid) begin
          $display("%0t: char_valid expected %b actual %b", $time,
                   exp_r.char_valid, got_r.char_valid);
          errors++;
        end
        if (got_r.halted !== exp_r.halted) begin
          $display("%0t: halted expected %b actual %b", $time, exp_r.halted, got_r.halted);
          errors++;
        end
        if (got_r.fault !== exp_r.fault) begin
          $display("%0t: fault expected %b actual %b", $time, exp_r.fault, got_r.fault);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int k;
    for (k = 0; k < 8; k++) gpr[k] = '0;
    pc_q = lc3ie_pkg::START_PC_RESET;
    flags_q = '0;
    stopped_q = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_ops();
    test_pc_extremes();
    test_random_programs();
    test_backpressure();
    test_halt_and_fault();
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      errors++;
    end
    $display("run: %0d requests, %0d results checked, %0d output characters, %0d errors",
             n_requests, n_results, n_chars, errors);
    $display("covered all supported opcodes, traps, pc wrap, stalls, fault and halt");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/lc3ie_pkg.sv
hdl/lc3ie_ctrl.sv
hdl/lc3ie_datapath.sv
hdl/lc3_instruction_execute_unit.sv
tb/tb_lc3_instruction_execute_unit.sv
